// File: rtl/core/qsu_pkg.sv
// Shared types, codes and helpers for the quoted string unescaper.
`timescale 1ns / 1ps

package qsu_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_data;
  } in_item_t;

  typedef struct packed {
    logic [2:0] out_kind;
    logic [7:0] out_value;
  } out_item_t;

  localparam logic [2:0] KIND_BYTE      = 3'd0;
  localparam logic [2:0] KIND_CLOSED    = 3'd1;
  localparam logic [2:0] KIND_BAD_START = 3'd2;
  localparam logic [2:0] KIND_CONTROL   = 3'd3;
  localparam logic [2:0] KIND_BAD_ESC   = 3'd4;
  localparam logic [2:0] KIND_BAD_HEX   = 3'd5;
  localparam logic [2:0] KIND_EARLY_END = 3'd6;

  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_X         = 8'h78;
  localparam logic [7:0] CH_BS_CODE   = 8'h08;
  localparam logic [7:0] CH_FF_CODE   = 8'h0C;

  typedef struct packed {
    logic       ok;
    logic [3:0] nibble;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t d;
    d.ok     = 1'b1;
    d.nibble = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.nibble = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      d.nibble = c[3:0] + 4'd9;
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

// File: rtl/core/quoted_string_unescaper.sv
// Top level of the quoted string unescaper.
`timescale 1ns / 1ps

// Decodes quoted strings from a byte stream, one byte per transfer. Between
// strings, blanks, tabs and CRs are skipped; a double or single quote opens a
// string, and each decoded byte comes out as kind 0 with its value. The
// matching quote gives kind 1; errors (bad start byte, control byte, bad
// escape, bad hex digit, end of data) give kinds 2 to 6 with a zero value and
// return the block to seeking. Opening quote, skip, backslash, the x of \x,
// the \x high digit and \CR bytes produce no result. An input register feeds
// the decoder state machine, whose result register accepts a new value
// whenever it is empty or being read, so a byte can be taken every cycle
// while out_ready stays high; the result register follows the input register.
module quoted_string_unescaper (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  qsu_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output qsu_pkg::out_item_t out_data
);

  logic              take;
  logic              item_valid;
  qsu_pkg::in_item_t item;

  qsu_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  qsu_decoder u_decoder (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// File: rtl/core/qsu_in_stage.sv
// Input register stage: holds one accepted transfer for the decoder.
`timescale 1ns / 1ps

module qsu_in_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  qsu_pkg::in_item_t in_data,
  input  logic             take,
  output logic             item_valid,
  output qsu_pkg::in_item_t item
);

  logic              vld_r;
  qsu_pkg::in_item_t data_r;

  assign in_ready   = !vld_r || take;
  assign item_valid = vld_r;
  assign item       = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      vld_r  <= 1'b1;
      data_r <= in_data;
    end else if (take) begin
      vld_r <= 1'b0;
    end
  end

endmodule

// File: rtl/core/qsu_decoder.sv
// Per-byte string decoder state machine with registered result.
`timescale 1ns / 1ps

module qsu_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  qsu_pkg::in_item_t  item,
  output logic               take,
  output logic               out_valid,
  input  logic               out_ready,
  output qsu_pkg::out_item_t out_data
);

  typedef enum logic [2:0] {
    SEEK, TAKE, ESC, ESC_CR, HEX0, HEX1, HEX1_BAD
  } mode_t;

  mode_t              mode_r, mode_nxt;
  logic               single_r, single_nxt;
  logic [3:0]         nib_r, nib_nxt;
  logic               out_valid_r;
  qsu_pkg::out_item_t out_data_r;

  logic               emit;
  logic [2:0]         kind;
  logic [7:0]         value;
  logic [7:0]         c;
  logic [7:0]         term;
  qsu_pkg::hex_digit_t hd;

  assign take      = item_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign c    = item.in_byte;
  assign term = single_r ? qsu_pkg::CH_SQUOTE : qsu_pkg::CH_DQUOTE;
  assign hd   = qsu_pkg::hex_decode(item.in_byte);

  always_comb begin
    mode_nxt   = mode_r;
    single_nxt = single_r;
    nib_nxt    = nib_r;
    emit       = 1'b0;
    kind       = qsu_pkg::KIND_BYTE;
    value      = 8'd0;
    if (item.end_of_data) begin
      mode_nxt = SEEK;
      emit     = 1'b1;
      kind     = qsu_pkg::KIND_EARLY_END;
    end else begin
      unique case (mode_r)
        TAKE: begin
          emit = 1'b1;
          if (c == qsu_pkg::CH_BACKSLASH) begin
            mode_nxt = ESC;
            emit     = 1'b0;
          end else if (c < qsu_pkg::CH_SPACE) begin
            mode_nxt = SEEK;
            kind     = qsu_pkg::KIND_CONTROL;
          end else if (c == term) begin
            mode_nxt = SEEK;
            kind     = qsu_pkg::KIND_CLOSED;
          end else begin
            value = c;
          end
        end
        ESC: begin
          emit     = 1'b1;
          mode_nxt = TAKE;
          if (c == qsu_pkg::CH_CR) begin
            mode_nxt = ESC_CR;
            emit     = 1'b0;
          end else if (c == qsu_pkg::CH_X) begin
            mode_nxt = HEX0;
            nib_nxt  = 4'd0;
            emit     = 1'b0;
          end else if (c == term || c == qsu_pkg::CH_BACKSLASH) begin
            value = c;
          end else if (c == qsu_pkg::CH_B) begin
            value = qsu_pkg::CH_BS_CODE;
          end else if (c == qsu_pkg::CH_F) begin
            value = qsu_pkg::CH_FF_CODE;
          end else if (c == qsu_pkg::CH_N || c == qsu_pkg::CH_LF) begin
            value = qsu_pkg::CH_LF;
          end else if (c == qsu_pkg::CH_R) begin
            value = qsu_pkg::CH_CR;
          end else if (c == qsu_pkg::CH_T) begin
            value = qsu_pkg::CH_TAB;
          end else begin
            mode_nxt = SEEK;
            kind     = qsu_pkg::KIND_BAD_ESC;
          end
        end
        ESC_CR: begin
          emit = 1'b1;
          if (c == qsu_pkg::CH_LF) begin
            mode_nxt = TAKE;
            value    = qsu_pkg::CH_LF;
          end else begin
            mode_nxt = SEEK;
            kind     = qsu_pkg::KIND_BAD_ESC;
          end
        end
        HEX0: begin
          if (hd.ok) begin
            nib_nxt  = hd.nibble;
            mode_nxt = HEX1;
          end else begin
            nib_nxt  = 4'd0;
            mode_nxt = HEX1_BAD;
          end
        end
        HEX1: begin
          emit = 1'b1;
          if (hd.ok) begin
            mode_nxt = TAKE;
            value    = {nib_r, hd.nibble};
          end else begin
            mode_nxt = SEEK;
            kind     = qsu_pkg::KIND_BAD_HEX;
          end
        end
        HEX1_BAD: begin
          emit     = 1'b1;
          mode_nxt = SEEK;
          kind     = qsu_pkg::KIND_BAD_HEX;
        end
        default: begin
          mode_nxt = SEEK;
          if (c == qsu_pkg::CH_SPACE || c == qsu_pkg::CH_TAB || c == qsu_pkg::CH_CR) begin
            emit = 1'b0;
          end else if (c == qsu_pkg::CH_DQUOTE || c == qsu_pkg::CH_SQUOTE) begin
            single_nxt = (c == qsu_pkg::CH_SQUOTE);
            mode_nxt   = TAKE;
          end else begin
            emit = 1'b1;
            kind = qsu_pkg::KIND_BAD_START;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= SEEK;
      single_r    <= 1'b0;
      nib_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else if (take) begin
      mode_r      <= mode_nxt;
      single_r    <= single_nxt;
      nib_r       <= nib_nxt;
      out_valid_r <= emit;
      out_data_r  <= '{out_kind: kind, out_value: value};
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule

// File: test/tb_quoted_string_unescaper.sv
// Testbench for quoted_string_unescaper: directed table plus random text, checked by a predictor and typed-in answers.
`timescale 1ns / 1ps

module tb_quoted_string_unescaper;

  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_Z     = 8'h7A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_G  = 8'h47;
  localparam int RANDOM_ITEMS = 1900;

  typedef enum logic [2:0] {
    SCAN_SEEK, SCAN_TAKE, SCAN_ESC, SCAN_ESC_CR, SCAN_HEX_HI, SCAN_HEX_LO, SCAN_HEX_LO_BAD
  } scan_t;

  // how a stream entry is checked: by the predictor, against a typed-in answer, or as giving no result
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} chk_t;

  typedef struct packed {
    qsu_pkg::in_item_t  item;
    chk_t               chk;
    qsu_pkg::out_item_t want;
  } text_row_t;

  localparam qsu_pkg::out_item_t NO_OUT = '{qsu_pkg::KIND_BYTE, 8'h00};
  localparam int DIR_ROWS = 29;
  localparam text_row_t DIRECTED [DIR_ROWS] = '{
    '{'{8'hFF, 1'b1}, CHK_ONE, '{qsu_pkg::KIND_EARLY_END, 8'h00}},
    '{'{8'h00, 1'b0}, CHK_ONE, '{qsu_pkg::KIND_BAD_START, 8'h00}},
    '{'{qsu_pkg::CH_SPACE, 1'b0}, CHK_NONE, NO_OUT},
    '{'{qsu_pkg::CH_CR, 1'b0}, CHK_NONE, NO_OUT},
    '{'{qsu_pkg::CH_DQUOTE, 1'b0}, CHK_NONE, NO_OUT},
    '{'{8'hFF, 1'b0}, CHK_ONE, '{qsu_pkg::KIND_BYTE, 8'hFF}},
    '{'{8'h1F, 1'b0}, CHK_ONE, '{qsu_pkg::KIND_CONTROL, 8'h00}},
    '{'{qsu_pkg::CH_SQUOTE, 1'b0}, CHK_NONE, NO_OUT},
    '{'{qsu_pkg::CH_DQUOTE, 1'b0}, CHK_MODEL, NO_OUT},
    '{'{qsu_pkg::CH_BACKSLASH, 1'b0}, CHK_NONE, NO_OUT},
    '{'{qsu_pkg::CH_F, 1'b0}, CHK_MODEL, NO_OUT},
    '{'{qsu_pkg::CH_BACKSLASH, 1'b0}, CHK_NONE, NO_OUT},
    '{'{qsu_pkg::CH_CR, 1'b0}, CHK_NONE, NO_OUT},
    '{'{qsu_pkg::CH_LF, 1'b0}, CHK_MODEL, NO_OUT},
    '{'{qsu_pkg::CH_BACKSLASH, 1'b0}, CHK_NONE, NO_OUT},
    '{'{qsu_pkg::CH_X, 1'b0}, CHK_NONE, NO_OUT},
    '{'{CH_LOW_A, 1'b0}, CHK_NONE, NO_OUT},
    '{'{8'h46, 1'b0}, CHK_MODEL, NO_OUT},
    '{'{qsu_pkg::CH_BACKSLASH, 1'b0}, CHK_NONE, NO_OUT},
    '{'{CH_U, 1'b0}, CHK_ONE, '{qsu_pkg::KIND_BAD_ESC, 8'h00}},
    '{'{qsu_pkg::CH_DQUOTE, 1'b0}, CHK_NONE, NO_OUT},
    '{'{qsu_pkg::CH_BACKSLASH, 1'b0}, CHK_NONE, NO_OUT},
    '{'{qsu_pkg::CH_X, 1'b0}, CHK_NONE, NO_OUT},
    '{'{CH_UP_G, 1'b0}, CHK_NONE, NO_OUT},
    '{'{CH_ZERO, 1'b0}, CHK_ONE, '{qsu_pkg::KIND_BAD_HEX, 8'h00}},
    '{'{qsu_pkg::CH_DQUOTE, 1'b0}, CHK_NONE, NO_OUT},
    '{'{8'h00, 1'b1}, CHK_ONE, '{qsu_pkg::KIND_EARLY_END, 8'h00}},
    '{'{qsu_pkg::CH_SQUOTE, 1'b0}, CHK_NONE, NO_OUT},
    '{'{qsu_pkg::CH_SQUOTE, 1'b0}, CHK_ONE, '{qsu_pkg::KIND_CLOSED, 8'h00}}
  };

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  qsu_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  qsu_pkg::out_item_t out_data;

  text_row_t          text_stream[$];
  qsu_pkg::out_item_t predicted_tokens[$];

  scan_t      scan;
  logic       single_q;
  logic [3:0] hi_nib;

  int taken;
  int n_out;
  int n_bytes;
  int n_faults;
  int errors;

  quoted_string_unescaper dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $error("timeout: %0d of %0d transfers in, %0d tokens pending",
           taken, text_stream.size(), predicted_tokens.size());
    $display("TB_ERROR");
    $finish;
  end

  // bit 4 set means not a hex digit
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, 4'(c - 8'h30)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b0, 4'(c - 8'h61 + 8'd10)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b0, 4'(c - 8'h41 + 8'd10)};
    return 5'h10;
  endfunction

  task automatic unescape_byte(input qsu_pkg::in_item_t it, output bit got,
                               output qsu_pkg::out_item_t tok);
    logic [7:0] c;
    logic [7:0] term;
    logic [4:0] d;
    c    = it.in_byte;
    term = single_q ? qsu_pkg::CH_SQUOTE : qsu_pkg::CH_DQUOTE;
    got  = 1'b1;
    tok  = NO_OUT;
    if (it.end_of_data) begin
      scan = SCAN_SEEK;
      tok.out_kind = qsu_pkg::KIND_EARLY_END;
    end else begin
      case (scan)
        SCAN_TAKE: begin
          if (c == qsu_pkg::CH_BACKSLASH) begin
            scan = SCAN_ESC;
            got = 1'b0;
          end else if (c < qsu_pkg::CH_SPACE) begin
            scan = SCAN_SEEK;
            tok.out_kind = qsu_pkg::KIND_CONTROL;
          end else if (c == term) begin
            scan = SCAN_SEEK;
            tok.out_kind = qsu_pkg::KIND_CLOSED;
          end else begin
            tok.out_value = c;
          end
        end
        SCAN_ESC: begin
          scan = SCAN_TAKE;
          if (c == qsu_pkg::CH_CR) begin
            scan = SCAN_ESC_CR;
            got = 1'b0;
          end else if (c == qsu_pkg::CH_X) begin
            scan = SCAN_HEX_HI;
            hi_nib = 4'd0;
            got = 1'b0;
          end else if (c == term || c == qsu_pkg::CH_BACKSLASH) begin
            tok.out_value = c;
          end else if (c == qsu_pkg::CH_B) begin
            tok.out_value = qsu_pkg::CH_BS_CODE;
          end else if (c == qsu_pkg::CH_F) begin
            tok.out_value = qsu_pkg::CH_FF_CODE;
          end else if (c == qsu_pkg::CH_N || c == qsu_pkg::CH_LF) begin
            tok.out_value = qsu_pkg::CH_LF;
          end else if (c == qsu_pkg::CH_R) begin
            tok.out_value = qsu_pkg::CH_CR;
          end else if (c == qsu_pkg::CH_T) begin
            tok.out_value = qsu_pkg::CH_TAB;
          end else begin
            scan = SCAN_SEEK;
            tok.out_kind = qsu_pkg::KIND_BAD_ESC;
          end
        end
        SCAN_ESC_CR: begin
          if (c == qsu_pkg::CH_LF) begin
            scan = SCAN_TAKE;
            tok.out_value = qsu_pkg::CH_LF;
          end else begin
            scan = SCAN_SEEK;
            tok.out_kind = qsu_pkg::KIND_BAD_ESC;
          end
        end
        SCAN_HEX_HI: begin
          d = hex_nibble(c);
          got = 1'b0;
          hi_nib = d[4] ? 4'd0 : d[3:0];
          scan = d[4] ? SCAN_HEX_LO_BAD : SCAN_HEX_LO;
        end
        SCAN_HEX_LO: begin
          d = hex_nibble(c);
          if (d[4]) begin
            scan = SCAN_SEEK;
            tok.out_kind = qsu_pkg::KIND_BAD_HEX;
          end else begin
            scan = SCAN_TAKE;
            tok.out_value = {hi_nib, d[3:0]};
          end
        end
        SCAN_HEX_LO_BAD: begin
          scan = SCAN_SEEK;
          tok.out_kind = qsu_pkg::KIND_BAD_HEX;
        end
        default: begin
          scan = SCAN_SEEK;
          if (c == qsu_pkg::CH_SPACE || c == qsu_pkg::CH_TAB || c == qsu_pkg::CH_CR) begin
            got = 1'b0;
          end else if (c == qsu_pkg::CH_DQUOTE || c == qsu_pkg::CH_SQUOTE) begin
            single_q = (c == qsu_pkg::CH_SQUOTE);
            scan = SCAN_TAKE;
            got = 1'b0;
          end else begin
            tok.out_kind = qsu_pkg::KIND_BAD_START;
          end
        end
      endcase
    end
  endtask

  task automatic push_text(input logic [7:0] b, input logic eod);
    text_row_t r;
    r.item = '{b, eod};
    r.chk  = CHK_MODEL;
    r.want = NO_OUT;
    text_stream.insert(text_stream.size(), r);
  endtask

  function automatic logic [7:0] rand_hex_digit();
    case ($urandom_range(0, 2))
      0:       return CH_ZERO + 8'($urandom_range(0, 9));
      1:       return CH_LOW_A + 8'($urandom_range(0, 5));
      default: return CH_UP_A + 8'($urandom_range(0, 5));
    endcase
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] b;
    logic [4:0] h;
    b = 8'($urandom_range(0, 255));
    h = hex_nibble(b);
    while (!h[4]) begin
      b = 8'($urandom_range(0, 255));
      h = hex_nibble(b);
    end
    return b;
  endfunction

  // one quoted string with random content, usually well formed
  task automatic gen_string();
    logic [7:0] q;
    logic [7:0] b;
    int n;
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 2))
        0:       push_text(qsu_pkg::CH_SPACE, 1'b0);
        1:       push_text(qsu_pkg::CH_TAB, 1'b0);
        default: push_text(qsu_pkg::CH_CR, 1'b0);
      endcase
    end
    q = $urandom_range(0, 1) ? qsu_pkg::CH_SQUOTE : qsu_pkg::CH_DQUOTE;
    push_text(q, 1'b0);
    n = $urandom_range(0, 12);
    repeat (n) begin
      if ($urandom_range(0, 9) < 6) begin
        b = 8'($urandom_range(8'h20, 8'hFF));
        if (b == q || b == qsu_pkg::CH_BACKSLASH) b = CH_Z;
        push_text(b, 1'b0);
      end else begin
        push_text(qsu_pkg::CH_BACKSLASH, 1'b0);
        case ($urandom_range(0, 9))
          0: push_text(q, 1'b0);
          1: push_text(qsu_pkg::CH_BACKSLASH, 1'b0);
          2: push_text(qsu_pkg::CH_B, 1'b0);
          3: push_text(qsu_pkg::CH_F, 1'b0);
          4: push_text(qsu_pkg::CH_N, 1'b0);
          5: push_text(qsu_pkg::CH_R, 1'b0);
          6: push_text(qsu_pkg::CH_T, 1'b0);
          7: push_text(qsu_pkg::CH_LF, 1'b0);
          8: begin
            push_text(qsu_pkg::CH_CR, 1'b0);
            push_text(qsu_pkg::CH_LF, 1'b0);
          end
          default: begin
            push_text(qsu_pkg::CH_X, 1'b0);
            push_text(rand_hex_digit(), 1'b0);
            push_text(rand_hex_digit(), 1'b0);
          end
        endcase
      end
    end
    case ($urandom_range(0, 19))
      0: push_text(8'($urandom_range(0, 31)), 1'b0);
      1: begin
        push_text(qsu_pkg::CH_BACKSLASH, 1'b0);
        case ($urandom_range(0, 2))
          0:       push_text(CH_U, 1'b0);
          1:       push_text(q == qsu_pkg::CH_SQUOTE ? qsu_pkg::CH_DQUOTE : qsu_pkg::CH_SQUOTE,
                             1'b0);
          default: push_text(8'($urandom_range(0, 255)), 1'b0);
        endcase
      end
      2: begin
        push_text(qsu_pkg::CH_BACKSLASH, 1'b0);
        push_text(qsu_pkg::CH_X, 1'b0);
        if ($urandom_range(0, 1)) begin
          push_text(rand_non_hex(), 1'b0);
          push_text(8'($urandom_range(0, 255)), 1'b0);
        end else begin
          push_text(rand_hex_digit(), 1'b0);
          push_text(rand_non_hex(), 1'b0);
        end
      end
      3: begin
        push_text(qsu_pkg::CH_BACKSLASH, 1'b0);
        push_text(qsu_pkg::CH_CR, 1'b0);
        b = 8'($urandom_range(0, 255));
        push_text(b == qsu_pkg::CH_LF ? CH_Z : b, 1'b0);
      end
      4: push_text(8'($urandom_range(0, 255)), 1'b1);
      5: ;
      default: push_text(q, 1'b0);
    endcase
  endtask

  // predict on every accepted input transfer
  always @(posedge clk) begin : take_mon
    bit                 got;
    qsu_pkg::out_item_t tok;
    text_row_t          r;
    if (rst_n && in_valid && in_ready) begin
      unescape_byte(in_data, got, tok);
      r = text_stream[taken];
      taken++;
      if (r.chk == CHK_MODEL) begin
        if (got) predicted_tokens.insert(predicted_tokens.size(), tok);
      end else if (r.chk == CHK_ONE) begin
        predicted_tokens.insert(predicted_tokens.size(), r.want);
      end
    end
  end

  always @(posedge clk) begin : out_mon
    qsu_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      n_out++;
      if (out_data.out_kind == qsu_pkg::KIND_BYTE) n_bytes++;
      else if (out_data.out_kind != qsu_pkg::KIND_CLOSED) n_faults++;
      if (predicted_tokens.size() == 0) begin
        $error("unexpected transfer: out_kind %0d out_value %02h",
               out_data.out_kind, out_data.out_value);
        errors++;
      end else begin
        want = predicted_tokens.pop_front();
        if (out_data.out_kind !== want.out_kind) begin
          $error("out_kind: expected %0d, got %0d", want.out_kind, out_data.out_kind);
          errors++;
        end
        if (out_data.out_value !== want.out_value) begin
          $error("out_value: expected %02h, got %02h", want.out_value, out_data.out_value);
          errors++;
        end
      end
    end
  end

  // receiver stalls on a repeating 8-bit mask, which is redrawn at random
  initial begin : sink
    logic [7:0] mask;
    int ph;
    out_ready = 1'b0;
    forever begin
      mask = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom_range(0, 255)) | 8'h01);
      ph = 0;
      repeat ($urandom_range(50, 300)) begin
        @(posedge clk);
        out_ready <= mask[ph % 8];
        ph++;
      end
    end
  end

  initial begin : source
    int sent;
    int burst;
    int gap;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    scan     = SCAN_SEEK;
    single_q = 1'b0;
    hi_nib   = 4'd0;
    for (int i = 0; i < DIR_ROWS; i++) text_stream.insert(text_stream.size(), DIRECTED[i]);
    while (text_stream.size() < DIR_ROWS + RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        push_text(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
      gen_string();
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    sent = 0;
    while (sent < text_stream.size()) begin
      burst = $urandom_range(1, 24);
      gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
      for (int k = 0; k < burst && sent < text_stream.size(); k++) begin
        in_valid <= 1'b1;
        in_data  <= text_stream[sent].item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent++;
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (predicted_tokens.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d input transfers; %0d results checked: %0d decoded bytes, %0d errors",
             taken, n_out, n_bytes, n_faults);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/qsu_pkg.sv
rtl/core/qsu_in_stage.sv
rtl/core/qsu_decoder.sv
rtl/core/quoted_string_unescaper.sv
test/tb_quoted_string_unescaper.sv
